>>> sv/packet_latency_tracker_top_macros.svh
// Assertion macros for the packet latency tracker top level.
// Depends on nothing; included by packet_latency_tracker_top.sv.
`ifndef PACKET_LATENCY_TRACKER_TOP_MACROS_SVH
`define PACKET_LATENCY_TRACKER_TOP_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define PLT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/plt_pkg.sv
// Package for the packet latency tracker: types, codes and helpers.
// Depends on nothing.
package plt_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int NODE_COUNT_DEF  = 64;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        EV_EMIT    = 3'd0,
        EV_ARRIVAL = 3'd1,
        EV_LEAVE   = 3'd2,
        EV_DELIVER = 3'd3,
        EV_DROP    = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_EMIT    = 2'd0,
        KIND_ARRIVAL = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_UPDATE,
        FSM_COUNT,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [31:0] packet_id;
        logic [31:0] flow_id;
        logic [31:0] timestamp;
        logic [6:0]  node_number;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] emitted_count;
        logic [31:0] forwarded_count;
        logic [31:0] received_count;
        logic [31:0] destroyed_count;
        logic [47:0] total_wait_time;
        logic [47:0] total_delay_time;
        logic [31:0] node_event_count;
        logic [31:0] highest_flow;
        logic [6:0]  live_entries;
    } out_item_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        write_en;
        logic        clear_en;
        logic        set_last;
        logic        set_all;
        logic [31:0] packet_id;
        logic [31:0] timestamp;
    } cell_cmd_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [47:0] sat_add(input logic [47:0] s, input logic [31:0] d);
        logic [48:0] r;
        r = {1'b0, s} + {17'd0, d};
        return (r > {1'b0, SUM_MAX}) ? SUM_MAX : r[47:0];
    endfunction
endpackage

>>> sv/plt_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module plt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> sv/plt_cell.sv
// One table cell: valid bit, packet id, departure and last event time.
// Depends on plt_pkg. Passes a found/free chain to its neighbour.
module plt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  plt_pkg::cell_cmd_t cmd,
    input  logic               select,
    input  logic [31:0]        key,
    input  logic               hit_in,
    input  logic               free_in,
    output logic               hit_out,
    output logic               free_out,
    output logic               match,
    output logic               first_free,
    output logic [31:0]        departure,
    output logic [31:0]        last_stamp
);
    logic        valid_reg;
    logic [31:0] packet_reg;
    logic [31:0] departure_reg;
    logic [31:0] last_reg;

    assign match      = valid_reg && (packet_reg == key) && !hit_in;
    assign first_free = !valid_reg && !free_in;
    assign hit_out    = hit_in || (valid_reg && packet_reg == key);
    assign free_out   = free_in || !valid_reg;
    assign departure  = departure_reg;
    assign last_stamp = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (select && cmd.write_en)
            valid_reg <= 1'b1;
        else if (select && cmd.clear_en)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (select && cmd.set_all)
        begin
            packet_reg    <= cmd.packet_id;
            departure_reg <= cmd.timestamp;
        end
        if (select && (cmd.set_all || cmd.set_last))
            last_reg <= cmd.timestamp;
    end
endmodule

>>> sv/plt_table.sv
// Row of table cells with a priority chain for match and first free slot.
// Depends on plt_pkg and plt_cell.
module plt_table #(
    parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  plt_pkg::cell_cmd_t           cmd,
    input  logic [31:0]                  key,
    input  logic                         use_hit,
    output logic                         found,
    output logic                         has_free,
    output logic [31:0]                  departure,
    output logic [31:0]                  last_stamp,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] live
);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    logic [TABLE_DEPTH:0]   hit_chain;
    logic [TABLE_DEPTH:0]   free_chain;
    logic [TABLE_DEPTH-1:0] match_v, free_v, sel_v;
    logic [31:0]            dep_a [TABLE_DEPTH];
    logic [31:0]            last_a [TABLE_DEPTH];
    logic [31:0]            dep_or, last_or;
    logic [LW-1:0]          live_reg, live_next;

    assign hit_chain[0]  = 1'b0;
    assign free_chain[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign sel_v[i] = use_hit ? match_v[i] : free_v[i];
        plt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .select    (sel_v[i]),
            .key       (key),
            .hit_in    (hit_chain[i]),
            .free_in   (free_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .free_out  (free_chain[i+1]),
            .match     (match_v[i]),
            .first_free(free_v[i]),
            .departure (dep_a[i]),
            .last_stamp(last_a[i])
        );
    end

    always_comb
    begin
        dep_or  = '0;
        last_or = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (match_v[i])
            begin
                dep_or  = dep_or | dep_a[i];
                last_or = last_or | last_a[i];
            end
        end
    end

    assign found      = hit_chain[TABLE_DEPTH];
    assign has_free   = free_chain[TABLE_DEPTH];
    assign departure  = dep_or;
    assign last_stamp = last_or;

    // live count tracks insertions and removals
    always_comb
    begin
        live_next = live_reg;
        if (cmd.write_en && !use_hit && has_free)
            live_next = live_reg + LW'(1);
        else if (cmd.clear_en && use_hit && found)
            live_next = live_reg - LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= '0;
        else
            live_reg <= live_next;
    end
    assign live = live_reg;
endmodule

>>> sv/packet_latency_tracker_top.sv
// Channel | dir | handshake       | payload
// in      | in  | in_valid/ready  | plt_pkg::in_item_t
// out     | out | out_valid/ready | plt_pkg::out_item_t
// Each transaction runs these steps from accept to accept: cell row search, table
// update and wait/delay totals; global counter update and per-node counter read;
// counter write-back and result register (out_valid rises); result handshake; idle.
// A new input is taken only once the result has gone; out stalls hold in_ready low.
// Reset clears the table valid bits, counters and totals; the per-node RAM is
// cleared by a sweep over every RAM address (4*NODE_COUNT rounded up to a power
// of two) after reset, with in_ready low.
// Depends on plt_pkg, plt_table, plt_ram and the macros header.
`include "packet_latency_tracker_top_macros.svh"
module packet_latency_tracker_top #(
    parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF,
    parameter int NODE_COUNT  = plt_pkg::NODE_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  plt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output plt_pkg::out_item_t out_data
);
    localparam int RAM_DEPTH = NODE_COUNT * 4;
    localparam int AW = $clog2(RAM_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);

    plt_pkg::fsm_t      state_reg, state_next;
    plt_pkg::in_item_t  item_reg;
    plt_pkg::cell_cmd_t cmd;
    logic               use_hit;
    logic               found, has_free;
    logic [31:0]        departure, last_stamp;
    logic [LW-1:0]      live;

    logic [31:0]        gcnt_reg [4];
    logic [47:0]        wait_reg, delay_reg;
    logic [31:0]        flow_reg;
    logic [1:0]         status_reg, status_next;
    logic               kind_ok_reg, kind_ok_next;
    logic [1:0]         kind_reg, kind_next;
    logic               node_ok;
    logic [AW:0]        clr_reg;
    logic               clearing;
    logic               out_valid_reg;
    plt_pkg::out_item_t out_reg;
    logic [31:0]        node_val;

    logic               ram_we;
    logic [AW-1:0]      ram_addr, node_addr;
    logic [31:0]        ram_wdata, ram_rdata;

    plt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .key       (item_reg.packet_id),
        .use_hit   (use_hit),
        .found     (found),
        .has_free  (has_free),
        .departure (departure),
        .last_stamp(last_stamp),
        .live      (live)
    );

    plt_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign clearing = !clr_reg[AW];
    assign node_ok  = (item_reg.node_number >= 7'd1)
                   && ({2'b0, item_reg.node_number} <= 9'(NODE_COUNT));
    assign node_addr = AW'(({1'b0, item_reg.node_number} - 8'd1) * 4 + {6'd0, kind_reg});
    assign in_ready  = (state_reg == plt_pkg::FSM_IDLE) && !clearing;
    assign node_val  = plt_pkg::sat_inc(ram_rdata);

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        kind_ok_next = kind_ok_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.packet_id = item_reg.packet_id;
        cmd.timestamp = item_reg.timestamp;
        use_hit      = 1'b1;
        ram_we       = 1'b0;
        ram_addr     = node_addr;
        ram_wdata    = node_val;
        if (clearing)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg[AW-1:0];
            ram_wdata = '0;
        end
        unique case (state_reg)
            plt_pkg::FSM_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = plt_pkg::FSM_SEARCH;
            end
            plt_pkg::FSM_SEARCH:
            begin
                status_next  = plt_pkg::ST_OK;
                kind_ok_next = 1'b0;
                kind_next    = plt_pkg::KIND_EMIT;
                unique case (item_reg.event_code)
                    plt_pkg::EV_EMIT:
                    begin
                        use_hit = found;
                        if (!found && !has_free)
                            status_next = plt_pkg::ST_FULL;
                        else
                        begin
                            cmd.write_en = 1'b1;
                            cmd.set_all  = 1'b1;
                            kind_ok_next = 1'b1;
                        end
                    end
                    plt_pkg::EV_ARRIVAL, plt_pkg::EV_LEAVE:
                    begin
                        if (!found)
                            status_next = plt_pkg::ST_NOT_FOUND;
                        else
                        begin
                            cmd.set_last = 1'b1;
                            kind_ok_next = (item_reg.event_code == plt_pkg::EV_ARRIVAL);
                            kind_next    = plt_pkg::KIND_ARRIVAL;
                        end
                    end
                    plt_pkg::EV_DELIVER:
                    begin
                        if (!found)
                            status_next = plt_pkg::ST_NOT_FOUND;
                        else
                        begin
                            cmd.clear_en = 1'b1;
                            kind_ok_next = 1'b1;
                            kind_next    = plt_pkg::KIND_DELIVER;
                        end
                    end
                    plt_pkg::EV_DROP:
                    begin
                        cmd.clear_en = 1'b1;
                        kind_ok_next = 1'b1;
                        kind_next    = plt_pkg::KIND_DROP;
                    end
                    default:
                        status_next = plt_pkg::ST_INVALID;
                endcase
                state_next = plt_pkg::FSM_UPDATE;
            end
            plt_pkg::FSM_UPDATE:
                state_next = plt_pkg::FSM_COUNT;
            plt_pkg::FSM_COUNT:
            begin
                ram_we     = kind_ok_reg && node_ok && (status_reg == plt_pkg::ST_OK);
                state_next = plt_pkg::FSM_DONE;
            end
            plt_pkg::FSM_DONE:
            begin
                if (out_ready || !out_valid_reg)
                    state_next = plt_pkg::FSM_IDLE;
            end
            default:
                state_next = plt_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= plt_pkg::FSM_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clearing)
            clr_reg <= clr_reg + (AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        status_reg  <= status_next;
        kind_ok_reg <= kind_ok_next;
        kind_reg    <= kind_next;
    end

    // totals: wait/delay use table values captured during the search cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                gcnt_reg[k] <= '0;
            wait_reg  <= '0;
            delay_reg <= '0;
            flow_reg  <= '0;
        end
        else if (state_reg == plt_pkg::FSM_SEARCH)
        begin
            if (item_reg.event_code == plt_pkg::EV_LEAVE && found)
                wait_reg <= plt_pkg::sat_add(wait_reg, item_reg.timestamp - last_stamp);
            if (item_reg.event_code == plt_pkg::EV_DELIVER && found)
                delay_reg <= plt_pkg::sat_add(delay_reg, item_reg.timestamp - departure);
        end
        else if (state_reg == plt_pkg::FSM_UPDATE && status_reg == plt_pkg::ST_OK)
        begin
            if (kind_ok_reg)
                gcnt_reg[kind_reg] <= plt_pkg::sat_inc(gcnt_reg[kind_reg]);
            if (item_reg.flow_id > flow_reg)
                flow_reg <= item_reg.flow_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == plt_pkg::FSM_COUNT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == plt_pkg::FSM_COUNT)
        begin
            out_reg.status           <= status_reg;
            out_reg.emitted_count    <= gcnt_reg[0];
            out_reg.forwarded_count  <= gcnt_reg[1];
            out_reg.received_count   <= gcnt_reg[2];
            out_reg.destroyed_count  <= gcnt_reg[3];
            out_reg.total_wait_time  <= wait_reg;
            out_reg.total_delay_time <= delay_reg;
            out_reg.node_event_count <= (kind_ok_reg && node_ok
                                         && status_reg == plt_pkg::ST_OK) ? node_val : 32'd0;
            out_reg.highest_flow     <= flow_reg;
            out_reg.live_entries     <= 7'(live);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PLT_ASSERT_IMPL(a_no_accept_clearing, clearing, !in_ready)
    `PLT_ASSERT_NEXT(a_search_follows_accept, in_valid && in_ready,
                     state_reg == plt_pkg::FSM_SEARCH)
    `PLT_ASSERT_IMPL(a_live_bound, 1'b1, live <= LW'(TABLE_DEPTH))
endmodule
